@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/utfd_pkg.sv @@
// ----------------------------------------------------------------------------
// utfd_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package utfd_pkg;

    localparam int CP_W = 21;

    localparam logic [7:0] BIT_TOP  = 8'h80;
    localparam logic [7:0] BIT_CONT = 8'h40;
    localparam logic [7:0] BIT_TWO  = 8'h20;
    localparam logic [7:0] BIT_THR  = 8'h10;
    localparam logic [7:0] BIT_FOUR = 8'h08;
    localparam logic [7:0] MASK_5   = 8'h1f;
    localparam logic [7:0] MASK_4   = 8'h0f;
    localparam logic [7:0] MASK_3   = 8'h07;
    localparam logic [7:0] MASK_6   = 8'h3f;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            err;
        logic            last;
    } t_result;

    typedef struct packed {
        logic [1:0]      pend;
        logic [CP_W-1:0] acc;
    } t_state;

    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

@@ design/utfd_decode.sv @@
// ----------------------------------------------------------------------------
// utfd_decode
// Byte decode: next decoder state and up to two results for one byte.
// ----------------------------------------------------------------------------
module utfd_decode (
    input  logic [7:0]       i_byte,
    input  logic             i_eos,
    input  utfd_pkg::t_state i_state,
    output utfd_pkg::t_state o_state,
    output utfd_pkg::t_push  o_push
);

    utfd_pkg::t_result res [2];
    utfd_pkg::t_result err_res;
    logic [1:0]        cnt;
    logic              is_lead;
    logic              is_ascii;
    logic              is_cont;
    logic [1:0]        pend_dec;

    always_comb begin
        err_res  = '{cp: '0, err: 1'b1, last: 1'b0};
        res[0]   = '0;
        res[1]   = '0;
        cnt      = 2'd0;
        is_lead  = 1'b0;
        o_state  = i_state;
        is_ascii = (i_byte & utfd_pkg::BIT_TOP) == 8'h00;
        is_cont  = !is_ascii && ((i_byte & utfd_pkg::BIT_CONT) == 8'h00);
        pend_dec = i_state.pend - 2'd1;

        if (i_state.pend != 2'd0) begin
            if (is_ascii) begin
                res[cnt[0]] = err_res;
                cnt         = cnt + 2'd1;
                o_state     = '0;
            end else if (is_cont) begin
                o_state.acc  = {i_state.acc[utfd_pkg::CP_W-7:0],
                                i_byte[5:0] & utfd_pkg::MASK_6[5:0]};
                o_state.pend = pend_dec;
                if (pend_dec == 2'd0) begin
                    res[cnt[0]] = '{cp: o_state.acc, err: 1'b0, last: 1'b0};
                    cnt         = cnt + 2'd1;
                    o_state     = '0;
                end
            end else begin
                res[cnt[0]] = err_res;
                cnt         = cnt + 2'd1;
                o_state     = '0;
                is_lead     = 1'b1;
            end
        end else begin
            if (is_ascii) begin
                res[cnt[0]] = '{cp: {{(utfd_pkg::CP_W-8){1'b0}}, i_byte},
                                err: 1'b0, last: 1'b0};
                cnt         = cnt + 2'd1;
            end else if (is_cont) begin
                res[cnt[0]] = err_res;
                cnt         = cnt + 2'd1;
            end else begin
                is_lead = 1'b1;
            end
        end

        if (is_lead) begin
            if ((i_byte & utfd_pkg::BIT_TWO) == 8'h00) begin
                o_state.acc  = {{(utfd_pkg::CP_W-8){1'b0}}, i_byte & utfd_pkg::MASK_5};
                o_state.pend = 2'd1;
            end else if ((i_byte & utfd_pkg::BIT_THR) == 8'h00) begin
                o_state.acc  = {{(utfd_pkg::CP_W-8){1'b0}}, i_byte & utfd_pkg::MASK_4};
                o_state.pend = 2'd2;
            end else if ((i_byte & utfd_pkg::BIT_FOUR) == 8'h00) begin
                o_state.acc  = {{(utfd_pkg::CP_W-8){1'b0}}, i_byte & utfd_pkg::MASK_3};
                o_state.pend = 2'd3;
            end else begin
                res[cnt[0]] = err_res;
                cnt         = cnt + 2'd1;
                o_state     = '0;
            end
        end

        if (i_eos && o_state.pend != 2'd0) begin
            res[cnt[0]] = err_res;
            cnt         = cnt + 2'd1;
            o_state     = '0;
        end

        if (cnt == 2'd1) begin
            res[0].last = 1'b1;
        end
        if (cnt == 2'd2) begin
            res[1].last = 1'b1;
        end

        o_push.num = cnt;
        o_push.r0  = res[0];
        o_push.r1  = res[1];
    end

endmodule

@@ design/utfd_out_queue.sv @@
// ----------------------------------------------------------------------------
// utfd_out_queue
// Four-entry result queue: takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module utfd_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  utfd_pkg::t_push   i_push,
    input  logic              i_push_en,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output utfd_pkg::t_result o_res
);

    utfd_pkg::t_result r_mem [4];
    logic [1:0]        r_wr_ptr;
    logic [1:0]        r_rd_ptr;
    logic [2:0]        r_count;
    logic [1:0]        n_wr_ptr;
    logic [1:0]        n_rd_ptr;
    logic [2:0]        n_count;
    logic [1:0]        push_n;
    logic              pop;

    assign push_n  = i_push_en ? i_push.num : 2'd0;
    assign pop     = o_valid && i_ready;
    assign o_valid = r_count != 3'd0;
    assign o_room  = r_count <= 3'd2;
    assign o_res   = r_mem[r_rd_ptr];

    assign n_wr_ptr = r_wr_ptr + push_n;
    assign n_rd_ptr = r_rd_ptr + {1'b0, pop};
    assign n_count  = r_count + {1'b0, push_n} - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_push.r1;
        end
    end

endmodule

@@ design/utf8_stream_decoder_top.sv @@
// An accepted byte sits in the input stage register, is decoded, and its results
// go to the result queue. One byte per cycle while the output is ready and
// each byte gives at most one result; two results need two output transfers.
// The four-entry result queue sets the stall point: input stalls at three held.
// Reset (synchronous, active low) clears decoder state, input stage and queue.
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// UTF-8 byte stream to code point decoder with error reporting.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [20:0] o_code_point,
    output logic        o_is_error,
    output logic        o_last_of_run
);

    logic              r_in_valid;
    logic [7:0]        r_byte;
    logic              r_eos;
    utfd_pkg::t_state  r_state;
    utfd_pkg::t_state  n_state;
    utfd_pkg::t_push   push;
    utfd_pkg::t_result out_res;
    logic              room;
    logic              advance;
    logic              accept;

    assign advance = r_in_valid && room;
    assign o_ready = !r_in_valid || advance;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_data_byte;
            r_eos  <= i_end_of_string;
        end
    end

    utfd_decode u_decode (
        .i_byte  (r_byte),
        .i_eos   (r_eos),
        .i_state (r_state),
        .o_state (n_state),
        .o_push  (push)
    );

    utfd_out_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_en (advance),
        .o_room    (room),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res     (out_res)
    );

    assign o_code_point  = out_res.cp;
    assign o_is_error    = out_res.err;
    assign o_last_of_run = out_res.last;

endmodule

@@ design/utfd_checker.sv @@
// ----------------------------------------------------------------------------
// utfd_checker
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [20:0] o_code_point,
    input logic        o_is_error,
    input logic        o_last_of_run
);

    `ASSERT_ALWAYS(a_err_zero_cp, i_clk, i_rst_n, !(o_valid && o_is_error) || (o_code_point == 21'd0))
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `ASSERT_NEXT(a_run_follows, i_clk, i_rst_n, o_valid && i_ready && !o_last_of_run, o_valid)
    `ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_valid)

endmodule

bind utf8_stream_decoder_top utfd_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_code_point  (o_code_point),
    .o_is_error    (o_is_error),
    .o_last_of_run (o_last_of_run)
);
